// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files of the lidar depth estimator
// depends on nothing; callers supply clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LRE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define LRE_ASSERT(lbl, prop)
`define LRE_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/lre_pkg.sv =====
// shared types and constants of the lidar roi depth estimator
// used by every module of the block
package lre_pkg;

  localparam logic OP_BOX   = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [2:0] REG_FOCAL_X     = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
  localparam logic [2:0] REG_PRINCIPAL_X = 3'd2;
  localparam logic [2:0] REG_PRINCIPAL_Y = 3'd3;
  localparam logic [2:0] REG_OFF_RIGHT   = 3'd4;
  localparam logic [2:0] REG_OFF_DOWN    = 3'd5;
  localparam logic [2:0] REG_OFF_FWD     = 3'd6;

  localparam int NUM_W = 39;
  localparam int DEN_W = 25;
  localparam logic [16:0] MAX_POINTS = 17'd65536;

  typedef struct packed {
    logic               op;
    logic [11:0]        col;
    logic [11:0]        row;
    logic [11:0]        wid;
    logic [11:0]        hgt;
    logic signed [19:0] fwd;
    logic signed [19:0] lft;
    logic signed [19:0] up;
    logic               last;
  } lre_item_t;

  typedef struct packed {
    logic [15:0]        focal_x;
    logic [15:0]        focal_y;
    logic [15:0]        principal_x;
    logic [15:0]        principal_y;
    logic signed [15:0] off_right;
    logic signed [15:0] off_down;
    logic signed [15:0] off_fwd;
  } lre_cfg_t;

endpackage

// ===== rtl/core/lre_front.sv =====
// front end: takes items on the command port into a two-entry queue
// depends on lre_pkg
module lre_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lre_pkg::lre_item_t in_item,
  input  logic              pop,
  output logic              q_valid,
  output lre_pkg::lre_item_t q_item
);
  import lre_pkg::*;

  lre_item_t   mem_r [2];
  logic        wr_r, rd_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_item;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "assert_macros.svh"
  `LRE_NEVER(a_cnt_range, cnt_r == 2'd3)
  `LRE_ASSERT(a_pop_nonempty, pop |-> q_valid)
  `LRE_ASSERT(a_full_next, (cnt_r == 2'd1 && push && !pop) |=> busy)
endmodule

// ===== rtl/core/lre_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on lre_pkg
module lre_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [lre_pkg::NUM_W-1:0]  num,
  input  logic [lre_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [lre_pkg::NUM_W-1:0]  quo
);
  import lre_pkg::*;

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial, diff;
  logic             qbit;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/lre_back.sv =====
// back end: sets the region from boxes, projects points, tests the region, keeps sums, forms the mean
// depends on lre_pkg and lre_div
module lre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lre_pkg::lre_cfg_t  cfg,
  input  logic               q_valid,
  input  lre_pkg::lre_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  output logic               out_measured,
  output logic signed [20:0] out_depth_mm,
  output logic [16:0]        out_inside_count
);
  import lre_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ZCHK, S_MULX, S_ADDX, S_DIVX, S_WAITX,
    S_MULY, S_ADDY, S_DIVY, S_WAITY, S_TEST, S_FIN, S_DIVM, S_WAITM
  } state_t;

  state_t             state_r;
  lre_item_t          ent_r;
  logic signed [20:0] cx_r, cy_r, cz_r;
  logic signed [37:0] prod_r;
  logic signed [38:0] num_r;
  logic signed [39:0] u_r, v_r;
  logic signed [13:0] left_r, right_r, top_r, bot_r;
  logic signed [35:0] sum_r;
  logic [16:0]        cnt_r;
  logic               out_valid_r, meas_r;
  logic signed [20:0] depth_r;
  logic [16:0]        ocnt_r;

  logic               div_go, div_done;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [DEN_W-1:0]   div_den;
  logic signed [39:0] qs;
  logic [9:0]         hw, hh;
  logic               in_roi;

  assign pop     = (state_r == S_IDLE) && q_valid;
  assign div_go  = (state_r == S_DIVX) || (state_r == S_DIVY) || (state_r == S_DIVM);
  assign div_num = num_r[38] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign div_den = (state_r == S_DIVM) ? {8'd0, cnt_r} : {1'b0, cz_r[19:0], 4'd0};
  assign qs      = num_r[38] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign hw      = ent_r.wid[11:2];
  assign hh      = ent_r.hgt[11:2];
  assign in_roi  = (u_r > $signed({{26{left_r[13]}}, left_r}))
                && (u_r < $signed({{26{right_r[13]}}, right_r}))
                && (v_r > $signed({{26{top_r[13]}}, top_r}))
                && (v_r < $signed({{26{bot_r[13]}}, bot_r}));

  lre_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign out_valid        = out_valid_r;
  assign out_measured     = meas_r;
  assign out_depth_mm     = depth_r;
  assign out_inside_count = ocnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
      top_r       <= '0;
      bot_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ent_r   <= q_item;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          if (ent_r.op == OP_BOX) begin
            left_r  <= $signed({2'b0, ent_r.col}) - $signed({4'd0, hw});
            right_r <= $signed({2'b0, ent_r.col}) + $signed({4'd0, hw});
            top_r   <= $signed({2'b0, ent_r.row}) - $signed({4'd0, hh});
            bot_r   <= $signed({2'b0, ent_r.row}) + $signed({4'd0, hh});
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cx_r    <= {{5{cfg.off_right[15]}}, cfg.off_right} - {ent_r.lft[19], ent_r.lft};
            cy_r    <= {{5{cfg.off_down[15]}}, cfg.off_down} - {ent_r.up[19], ent_r.up};
            cz_r    <= {{5{cfg.off_fwd[15]}}, cfg.off_fwd} + {ent_r.fwd[19], ent_r.fwd};
            state_r <= S_ZCHK;
          end
        end
        S_ZCHK: begin
          state_r <= (cz_r > 21'sd0) ? S_MULX : S_FIN;
        end
        S_MULX: begin
          prod_r  <= $signed({1'b0, cfg.focal_x}) * cx_r;
          state_r <= S_ADDX;
        end
        S_ADDX: begin
          num_r   <= {prod_r[37], prod_r} + $signed({1'b0, cfg.principal_x}) * cz_r;
          state_r <= S_DIVX;
        end
        S_DIVX: begin
          state_r <= S_WAITX;
        end
        S_WAITX: begin
          if (div_done) begin
            u_r     <= qs;
            state_r <= S_MULY;
          end
        end
        S_MULY: begin
          prod_r  <= $signed({1'b0, cfg.focal_y}) * cy_r;
          state_r <= S_ADDY;
        end
        S_ADDY: begin
          num_r   <= {prod_r[37], prod_r} + $signed({1'b0, cfg.principal_y}) * cz_r;
          state_r <= S_DIVY;
        end
        S_DIVY: begin
          state_r <= S_WAITY;
        end
        S_WAITY: begin
          if (div_done) begin
            v_r     <= qs;
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (in_roi && (cnt_r < MAX_POINTS)) begin
            sum_r <= sum_r + {{16{ent_r.fwd[19]}}, ent_r.fwd};
            cnt_r <= cnt_r + 17'd1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!ent_r.last) begin
            state_r <= S_IDLE;
          end else if (cnt_r == 17'd0) begin
            meas_r      <= 1'b0;
            depth_r     <= '0;
            ocnt_r      <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            num_r   <= {{3{sum_r[35]}}, sum_r};
            state_r <= S_DIVM;
          end
        end
        S_DIVM: begin
          state_r <= S_WAITM;
        end
        S_WAITM: begin
          if (div_done) begin
            meas_r      <= 1'b1;
            depth_r     <= qs[20:0] + {{5{cfg.off_fwd[15]}}, cfg.off_fwd};
            ocnt_r      <= cnt_r;
            out_valid_r <= 1'b1;
            sum_r       <= '0;
            cnt_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `LRE_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r)
  `LRE_NEVER(a_count_cap, cnt_r > MAX_POINTS)
  `LRE_ASSERT(a_result_clears, out_valid_r |-> (cnt_r == 17'd0 && sum_r == 36'sd0))
  `LRE_ASSERT(a_meas_count, (out_valid_r && meas_r) |-> (ocnt_r != 17'd0))
endmodule

// ===== rtl/core/lidar_roi_depth_estimator.sv =====
// a last point is projected, tested and then divided for the mean; if the count is zero
// the result comes without the mean division, and a point with cz <= 0 skips projection
// the back end takes one queued item at a time and holds it until its steps are done
// busy rises when the two-entry queue is full; results cannot be stalled
// synchronous reset clears region, sums, queue and loads config defaults
module lidar_roi_depth_estimator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [11:0]        in_box_center_col,
  input  logic [11:0]        in_box_center_row,
  input  logic [11:0]        in_box_width,
  input  logic [11:0]        in_box_height,
  input  logic signed [19:0] in_point_fwd,
  input  logic signed [19:0] in_point_left,
  input  logic signed [19:0] in_point_up,
  input  logic               in_last_point,
  output logic               out_valid,
  output logic               out_measured,
  output logic signed [20:0] out_depth_mm,
  output logic [16:0]        out_inside_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import lre_pkg::*;

  lre_cfg_t  cfg_r;
  lre_item_t in_item, q_item;
  logic      q_valid, pop;

  assign in_item = '{op: in_op, col: in_box_center_col, row: in_box_center_row,
                     wid: in_box_width, hgt: in_box_height, fwd: in_point_fwd,
                     lft: in_point_left, up: in_point_up, last: in_last_point};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x     <= 16'd9600;
      cfg_r.focal_y     <= 16'd9600;
      cfg_r.principal_x <= 16'd5120;
      cfg_r.principal_y <= 16'd3840;
      cfg_r.off_right   <= -16'sd37;
      cfg_r.off_down    <= 16'sd32;
      cfg_r.off_fwd     <= 16'sd48;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:     cfg_r.focal_x     <= cfg_wdata;
        REG_FOCAL_Y:     cfg_r.focal_y     <= cfg_wdata;
        REG_PRINCIPAL_X: cfg_r.principal_x <= cfg_wdata;
        REG_PRINCIPAL_Y: cfg_r.principal_y <= cfg_wdata;
        REG_OFF_RIGHT:   cfg_r.off_right   <= cfg_wdata;
        REG_OFF_DOWN:    cfg_r.off_down    <= cfg_wdata;
        REG_OFF_FWD:     cfg_r.off_fwd     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lre_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_item(in_item),
    .pop    (pop),
    .q_valid(q_valid),
    .q_item (q_item)
  );

  lre_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_measured    (out_measured),
    .out_depth_mm    (out_depth_mm),
    .out_inside_count(out_inside_count)
  );
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of lidar_roi_depth_estimator: directed and random items
// against an in-bench depth predictor; depends on lre_pkg and the block's rtl
module tb_top;
  import lre_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic               measured;
    logic signed [20:0] depth;
    logic [16:0]        count;
  } depth_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  lre_item_t drv;
  logic out_valid;
  logic out_measured;
  logic signed [20:0] out_depth_mm;
  logic [16:0] out_inside_count;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  lre_cfg_t cam_cfg;
  longint roi_left, roi_right, roi_top, roi_bottom;
  longint fwd_sum, inside_cnt;
  depth_result_t pending_depths[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;

  lidar_roi_depth_estimator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(drv.op), .in_box_center_col(drv.col), .in_box_center_row(drv.row),
    .in_box_width(drv.wid), .in_box_height(drv.hgt), .in_point_fwd(drv.fwd),
    .in_point_left(drv.lft), .in_point_up(drv.up), .in_last_point(drv.last),
    .out_valid(out_valid), .out_measured(out_measured), .out_depth_mm(out_depth_mm),
    .out_inside_count(out_inside_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("error at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lidar_roi_depth_estimator: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    depth_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_depths.size() == 0) begin
        report("result with none expected");
      end else begin
        exp_r = pending_depths.pop_front();
        if (out_measured !== exp_r.measured)
          report($sformatf("measured %b want %b", out_measured, exp_r.measured));
        if (out_depth_mm !== exp_r.depth)
          report($sformatf("depth %0d want %0d", out_depth_mm, exp_r.depth));
        if (out_inside_count !== exp_r.count)
          report($sformatf("count %0d want %0d", out_inside_count, exp_r.count));
      end
    end
  end

  function automatic void predict_depth(input lre_item_t it);
    longint fwd, lft, up, cx, cy, cz, den, u, v, depth;
    depth_result_t r;
    if (it.op == OP_BOX) begin
      roi_left = longint'(it.col) - longint'(it.wid >> 2);
      roi_right = longint'(it.col) + longint'(it.wid >> 2);
      roi_top = longint'(it.row) - longint'(it.hgt >> 2);
      roi_bottom = longint'(it.row) + longint'(it.hgt >> 2);
      fwd_sum = 0;
      inside_cnt = 0;
      return;
    end
    fwd = longint'(it.fwd);
    lft = longint'(it.lft);
    up = longint'(it.up);
    cx = -lft + longint'(cam_cfg.off_right);
    cy = -up + longint'(cam_cfg.off_down);
    cz = fwd + longint'(cam_cfg.off_fwd);
    if (cz > 0) begin
      den = 16 * cz;
      u = (longint'(cam_cfg.focal_x) * cx + longint'(cam_cfg.principal_x) * cz) / den;
      v = (longint'(cam_cfg.focal_y) * cy + longint'(cam_cfg.principal_y) * cz) / den;
      if (u > roi_left && u < roi_right && v > roi_top && v < roi_bottom &&
          inside_cnt < longint'(MAX_POINTS)) begin
        fwd_sum += fwd;
        inside_cnt += 1;
      end
    end
    if (!it.last) return;
    if (inside_cnt > 0) begin
      depth = fwd_sum / inside_cnt + longint'(cam_cfg.off_fwd);
      r.measured = 1'b1;
      r.depth = depth[20:0];
      r.count = inside_cnt[16:0];
    end else begin
      r.measured = 1'b0;
      r.depth = '0;
      r.count = '0;
    end
    pending_depths = {pending_depths, r};
    fwd_sum = 0;
    inside_cnt = 0;
  endfunction

  task automatic send_item(input lre_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drv <= it;
    start <= 1'b1;
    while (busy) @(negedge clk);
    predict_depth(it);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_depths.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL_X:     cam_cfg.focal_x = val;
      REG_FOCAL_Y:     cam_cfg.focal_y = val;
      REG_PRINCIPAL_X: cam_cfg.principal_x = val;
      REG_PRINCIPAL_Y: cam_cfg.principal_y = val;
      REG_OFF_RIGHT:   cam_cfg.off_right = val;
      REG_OFF_DOWN:    cam_cfg.off_down = val;
      REG_OFF_FWD:     cam_cfg.off_fwd = val;
      default: ;
    endcase
  endtask

  task automatic set_camera(input logic [15:0] fx, fy, px, py, orr, od, of);
    drain();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_PRINCIPAL_X, px);
    write_reg(REG_PRINCIPAL_Y, py);
    write_reg(REG_OFF_RIGHT, orr);
    write_reg(REG_OFF_DOWN, od);
    write_reg(REG_OFF_FWD, of);
  endtask

  function automatic lre_item_t box_item(input int col, row, wid, hgt);
    lre_item_t it = '0;
    it.op = OP_BOX;
    it.col = col[11:0];
    it.row = row[11:0];
    it.wid = wid[11:0];
    it.hgt = hgt[11:0];
    return it;
  endfunction

  function automatic lre_item_t raw_point(input longint fwd, lft, up, input bit last);
    lre_item_t it = '0;
    it.op = OP_POINT;
    it.fwd = fwd[19:0];
    it.lft = lft[19:0];
    it.up = up[19:0];
    it.last = last;
    return it;
  endfunction

  function automatic longint clamp20(input longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return x;
  endfunction

  // aims a point at a pixel inside the current region when the camera allows
  function automatic lre_item_t aimed_point(input bit last);
    longint cz, pu, pv, cx, cy;
    cz = $urandom_range(60000, 1);
    pu = (roi_right - roi_left >= 2) ?
         roi_left + 1 + $urandom_range(int'(roi_right - roi_left - 2)) : 100;
    pv = (roi_bottom - roi_top >= 2) ?
         roi_top + 1 + $urandom_range(int'(roi_bottom - roi_top - 2)) : 100;
    cx = (cam_cfg.focal_x == 0) ? longint'($urandom_range(2000)) - 1000 :
         ((16 * pu + 8 - longint'(cam_cfg.principal_x)) * cz) / longint'(cam_cfg.focal_x);
    cy = (cam_cfg.focal_y == 0) ? longint'($urandom_range(2000)) - 1000 :
         ((16 * pv + 8 - longint'(cam_cfg.principal_y)) * cz) / longint'(cam_cfg.focal_y);
    return raw_point(clamp20(cz - longint'(cam_cfg.off_fwd)),
                     clamp20(longint'(cam_cfg.off_right) - cx),
                     clamp20(longint'(cam_cfg.off_down) - cy), last);
  endfunction

  function automatic lre_item_t noise_item;
    logic [127:0] raw;
    lre_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(lre_item_t)-1:0];
    return it;
  endfunction

  task automatic test_directed;
    send_item(raw_point(1000, 0, 0, 1'b1));
    send_item(box_item(320, 240, 200, 150));
    send_item(aimed_point(1'b0));
    send_item(aimed_point(1'b0));
    send_item(raw_point(-48, 0, 0, 1'b0));
    send_item(raw_point(-524288, 0, 0, 1'b0));
    send_item(aimed_point(1'b1));
    send_item(aimed_point(1'b0));
    send_item(aimed_point(1'b1));
    send_item(raw_point(-524288, -524288, -524288, 1'b1));
    send_item(box_item(4095, 4095, 4095, 4095));
    send_item(raw_point(524287, 524287, 524287, 1'b0));
    send_item(raw_point(524287, -524288, -524288, 1'b1));
    send_item(box_item(0, 0, 0, 0));
    send_item(raw_point(5000, 0, 0, 1'b1));
    send_item(box_item(0, 0, 4095, 4095));
    send_item(aimed_point(1'b0));
    send_item(aimed_point(1'b1));
    send_item(box_item(320, 240, 3, 7));
    send_item(aimed_point(1'b1));
  endtask

  task automatic test_camera_extremes;
    set_camera(16'd0, 16'd0, 16'd8000, 16'd6000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(box_item(500, 375, 40, 40));
    send_item(raw_point(1000, 300, -200, 1'b0));
    send_item(raw_point(-32767, 0, 0, 1'b0));
    send_item(raw_point(-40000, 0, 0, 1'b1));
    set_camera(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000);
    drain();
    write_reg(REG_NONE, 16'h1234);
    send_item(box_item(4095, 4095, 2000, 2000));
    send_item(aimed_point(1'b0));
    send_item(raw_point(32768, 0, 0, 1'b0));
    send_item(aimed_point(1'b1));
  endtask

  task automatic test_random_clouds(input int n_items);
    int sent;
    int n_pts;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_item(noise_item());
        sent++;
      end else begin
        if ($urandom_range(99) < 80)
          send_item(box_item($urandom_range(1500), $urandom_range(1200),
                             $urandom_range(1200), $urandom_range(1000)));
        else
          send_item(box_item($urandom_range(4095), $urandom_range(4095),
                             $urandom_range(4095), $urandom_range(4095)));
        n_pts = $urandom_range(12);
        for (int i = 0; i < n_pts; i++)
          send_item(($urandom_range(99) < 75) ? aimed_point(1'b0) :
                    raw_point(clamp20(longint'($urandom_range(4000)) - 2000),
                              clamp20(longint'($urandom_range(8000)) - 4000),
                              clamp20(longint'($urandom_range(8000)) - 4000), 1'b0));
        send_item(aimed_point(1'b1));
        sent += n_pts + 2;
      end
      if ($urandom_range(99) < 4) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    drv = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cam_cfg = '{focal_x: 16'd9600, focal_y: 16'd9600, principal_x: 16'd5120,
                principal_y: 16'd3840, off_right: -16'sd37, off_down: 16'sd32,
                off_fwd: 16'sd48};
    roi_left = 0; roi_right = 0; roi_top = 0; roi_bottom = 0;
    fwd_sum = 0; inside_cnt = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 35;
    test_directed();
    test_camera_extremes();
    set_camera(16'd9600, 16'd9600, 16'd5120, 16'd3840, -16'sd37, 16'sd32, 16'sd48);
    test_random_clouds(420);
    send_idle_pct = 67;
    set_camera(16'd4000, 16'd12000, 16'd2000, 16'd9000, 16'sd500, -16'sd800, -16'sd300);
    test_random_clouds(400);
    send_idle_pct = 0;
    set_camera(16'd30000, 16'd1600, 16'd30000, 16'd1000, -16'sd2000, 16'sd1500, 16'sd900);
    test_random_clouds(420);
    drain();
    if (errors == 0)
      $display("lidar_roi_depth_estimator: match");
    else
      $display("lidar_roi_depth_estimator: mismatch");
    $finish;
  end
endmodule
